// ===== hw/rtl/spim_pkg.sv =====
// Shared types and constants for the SPI master serializer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package spim_pkg;

    localparam int ACTION_W           = 2;
    localparam int WORD_W             = 16;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 5;
    localparam int PRESCALE_W         = 8;
    localparam int DEF_MAX_FRAME_BITS = 16;
    localparam int MIN_FRAME_BITS     = 4;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_BITS = 5'd8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_SEND    = 2'd1,
        ACT_ENABLE  = 2'd2,
        ACT_DISABLE = 2'd3
    } t_action;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLOCK_PHASE    = 3'd0,
        CFG_CLOCK_POLARITY = 3'd1,
        CFG_RATE_EXPONENT  = 3'd2,
        CFG_LSB_FIRST      = 3'd3,
        CFG_FRAME_BITS     = 3'd4,
        CFG_SOFT_SELECT    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                  clock_phase;
        logic                  clock_polarity;
        logic [2:0]            rate_exponent;
        logic                  lsb_first_order;
        logic [CFG_DATA_W-1:0] frame_bits;
        logic                  soft_select;
    } t_spim_cfg;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [WORD_W-1:0]   tx_word;
        logic                miso;
    } t_spim_item;

    typedef struct packed {
        logic              sck;
        logic              mosi;
        logic              nss;
        logic              nss_drive;
        logic [WORD_W-1:0] rx_word;
        logic              rx_valid;
        logic              tx_ready;
        logic              busy_res;
    } t_spim_res;

endpackage

// ===== hw/rtl/spim_in_if.sv =====
// Request channel into the SPI master: one peripheral tick per request.
// Depends on spim_pkg.
`timescale 1ns / 1ps

interface spim_in_if;
    import spim_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   tx_word;
    logic                miso;

    modport source (output valid, output action, output tx_word, output miso, input ready);
    modport sink   (input valid, input action, input tx_word, input miso, output ready);
endinterface

// ===== hw/rtl/spim_out_if.sv =====
// Result channel out of the SPI master: line levels and status per tick.
// Depends on spim_pkg.
`timescale 1ns / 1ps

interface spim_out_if;
    import spim_pkg::*;

    logic              valid;
    logic              ready;
    logic              sck;
    logic              mosi;
    logic              nss;
    logic              nss_drive;
    logic [WORD_W-1:0] rx_word;
    logic              rx_valid;
    logic              tx_ready;
    logic              busy_res;

    modport source (output valid, output sck, output mosi, output nss, output nss_drive,
                    output rx_word, output rx_valid, output tx_ready, output busy_res,
                    input ready);
    modport sink   (input valid, input sck, input mosi, input nss, input nss_drive,
                    input rx_word, input rx_valid, input tx_ready, input busy_res,
                    output ready);
endinterface

// ===== hw/rtl/spim_cfg.sv =====
// Configuration register bank of the SPI master.
// Depends on spim_pkg.
`timescale 1ns / 1ps

module spim_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spim_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [spim_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output spim_pkg::t_spim_cfg                o_cfg
);
    import spim_pkg::*;

    t_spim_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_phase     <= 1'b0;
            r_cfg.clock_polarity  <= 1'b0;
            r_cfg.rate_exponent   <= 3'd0;
            r_cfg.lsb_first_order <= 1'b0;
            r_cfg.frame_bits      <= RST_FRAME_BITS;
            r_cfg.soft_select     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLOCK_PHASE:    r_cfg.clock_phase     <= i_cfg_data[0];
                CFG_CLOCK_POLARITY: r_cfg.clock_polarity  <= i_cfg_data[0];
                CFG_RATE_EXPONENT:  r_cfg.rate_exponent   <= i_cfg_data[2:0];
                CFG_LSB_FIRST:      r_cfg.lsb_first_order <= i_cfg_data[0];
                CFG_FRAME_BITS:     r_cfg.frame_bits      <= i_cfg_data;
                CFG_SOFT_SELECT:    r_cfg.soft_select     <= i_cfg_data[0];
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/spim_in_stage.sv =====
// Input register of the SPI master: captures one request per cycle while the held request moves on.
// Depends on spim_pkg and spim_in_if.
`timescale 1ns / 1ps

module spim_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spim_in_if.sink              i_req,
    input  logic                 i_take,
    output logic                 o_valid,
    output spim_pkg::t_spim_item o_item
);
    import spim_pkg::*;

    logic       r_valid;
    t_spim_item r_item;
    logic       accept;

    // refill in the same cycle the held request moves on
    assign i_req.ready = !r_valid || i_take;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.action  <= i_req.action;
            r_item.tx_word <= i_req.tx_word;
            r_item.miso    <= i_req.miso;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/spim_core.sv =====
// Serializer state and result register of the SPI master: one tick per request.
// Depends on spim_pkg and spim_out_if.
`timescale 1ns / 1ps

module spim_core #(
    parameter int MAX_FRAME_BITS = spim_pkg::DEF_MAX_FRAME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spim_pkg::t_spim_cfg  i_cfg,
    input  logic                 i_valid,
    input  spim_pkg::t_spim_item i_item,
    output logic                 o_ready,
    spim_out_if.source           o_res
);
    import spim_pkg::*;

    localparam int W  = MAX_FRAME_BITS;
    localparam int LW = $clog2(W + 1);
    localparam int IW = $clog2(W);

    // state
    logic                  r_enabled, n_enabled;
    logic                  r_disable_pending, n_disable_pending;
    logic                  r_hold_full, n_hold_full;
    logic [W-1:0]          r_hold_word, n_hold_word;
    logic [W-1:0]          r_tx_shift, n_tx_shift;
    logic [W-1:0]          r_rx_shift, n_rx_shift;
    logic [LW-1:0]         r_bit_count, n_bit_count;
    logic [PRESCALE_W-1:0] r_prescale, n_prescale;
    logic                  r_clock_level, n_clock_level;
    logic                  r_mosi_level, n_mosi_level;

    // result register
    logic                  r_out_valid;
    t_spim_res             r_out, n_out;

    logic                  fire;
    logic [LW-1:0]         frame_len;
    logic [W-1:0]          frame_mask;
    logic [PRESCALE_W-1:0] half;
    logic                  done;
    logic [WORD_W-1:0]     rx_out;

    function automatic logic [W-1:0] len_mask(input logic [LW-1:0] l);
        logic [W-1:0] m;
        for (int i = 0; i < W; i++) begin
            m[i] = (i < int'(l));
        end
        return m;
    endfunction

    function automatic logic [IW-1:0] top_index(input logic [LW-1:0] l);
        logic [LW-1:0] t;
        t = l - LW'(1);
        return t[IW-1:0];
    endfunction

    function automatic logic cur_bit(input logic [W-1:0] tx, input logic [LW-1:0] l,
                                     input logic lsb);
        return lsb ? tx[0] : tx[top_index(l)];
    endfunction

    function automatic logic [W-1:0] sample(input logic [W-1:0] rx, input logic m,
                                            input logic [LW-1:0] l, input logic lsb,
                                            input logic [W-1:0] mask);
        logic [W-1:0] v;
        if (lsb) begin
            v = (rx >> 1) | (W'(m) << top_index(l));
        end else begin
            v = (rx << 1) | W'(m);
        end
        return v & mask;
    endfunction

    function automatic logic [W-1:0] widen_word(input logic [WORD_W-1:0] word);
        logic [W+WORD_W-1:0] v;
        v = {{W{1'b0}}, word};
        return v[W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] low_word(input logic [W-1:0] x);
        logic [W+WORD_W-1:0] v;
        v = {{WORD_W{1'b0}}, x};
        return v[WORD_W-1:0];
    endfunction

    assign o_ready = !r_out_valid || o_res.ready;
    assign fire    = i_valid && o_ready;

    always_comb begin
        if (i_cfg.frame_bits < CFG_DATA_W'(MIN_FRAME_BITS)) begin
            frame_len = LW'(MIN_FRAME_BITS);
        end else if (int'(i_cfg.frame_bits) > W) begin
            frame_len = LW'(W);
        end else begin
            frame_len = LW'(i_cfg.frame_bits);
        end
    end

    assign frame_mask = len_mask(frame_len);
    assign half       = PRESCALE_W'(1) << i_cfg.rate_exponent;

    // next state for one tick: action, then shifter, then pending disable
    always_comb begin
        n_enabled         = r_enabled;
        n_disable_pending = r_disable_pending;
        n_hold_full       = r_hold_full;
        n_hold_word       = r_hold_word;
        n_tx_shift        = r_tx_shift;
        n_rx_shift        = r_rx_shift;
        n_bit_count       = r_bit_count;
        n_prescale        = r_prescale;
        n_clock_level     = r_clock_level;
        n_mosi_level      = r_mosi_level;
        done              = 1'b0;

        if (fire) begin
            case (t_action'(i_item.action))
                ACT_SEND: begin
                    if (!r_hold_full) begin
                        n_hold_word = widen_word(i_item.tx_word) & frame_mask;
                        n_hold_full = 1'b1;
                    end
                end
                ACT_ENABLE: begin
                    n_enabled         = 1'b1;
                    n_disable_pending = 1'b0;
                end
                ACT_DISABLE: begin
                    if (r_enabled) begin
                        n_disable_pending = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (r_bit_count != '0) begin
                n_prescale = r_prescale + PRESCALE_W'(1);
                if (n_prescale >= half) begin
                    n_prescale = '0;
                    if (!r_clock_level) begin
                        // leading edge
                        n_clock_level = 1'b1;
                        if (i_cfg.clock_phase) begin
                            n_mosi_level = cur_bit(r_tx_shift, frame_len,
                                                   i_cfg.lsb_first_order);
                        end else begin
                            n_rx_shift = sample(r_rx_shift, i_item.miso, frame_len,
                                                i_cfg.lsb_first_order, frame_mask);
                        end
                    end else begin
                        // trailing edge
                        n_clock_level = 1'b0;
                        if (i_cfg.clock_phase) begin
                            n_rx_shift = sample(r_rx_shift, i_item.miso, frame_len,
                                                i_cfg.lsb_first_order, frame_mask);
                        end
                        if (i_cfg.lsb_first_order) begin
                            n_tx_shift = r_tx_shift >> 1;
                        end else begin
                            n_tx_shift = (r_tx_shift << 1) & frame_mask;
                        end
                        n_bit_count = r_bit_count - LW'(1);
                        if (n_bit_count == '0) begin
                            done = 1'b1;
                        end else if (!i_cfg.clock_phase) begin
                            n_mosi_level = cur_bit(n_tx_shift, frame_len,
                                                   i_cfg.lsb_first_order);
                        end
                    end
                end
            end else if (n_enabled && n_hold_full) begin
                // a word sent on this same tick loads straight away
                n_tx_shift    = n_hold_word & frame_mask;
                n_hold_full   = 1'b0;
                n_rx_shift    = '0;
                n_bit_count   = frame_len;
                n_prescale    = '0;
                n_clock_level = 1'b0;
                n_mosi_level  = cur_bit(n_tx_shift, frame_len, i_cfg.lsb_first_order);
            end

            if (n_disable_pending && (n_bit_count == '0) && !n_hold_full) begin
                n_enabled         = 1'b0;
                n_disable_pending = 1'b0;
            end
        end
    end

    assign rx_out = done ? low_word(n_rx_shift) : '0;

    always_comb begin
        n_out.sck       = i_cfg.clock_polarity ^ n_clock_level;
        n_out.mosi      = n_mosi_level;
        n_out.nss       = i_cfg.soft_select ? 1'b1 : !n_enabled;
        n_out.nss_drive = !i_cfg.soft_select;
        n_out.rx_word   = rx_out;
        n_out.rx_valid  = done;
        n_out.tx_ready  = !n_hold_full;
        n_out.busy_res  = (n_bit_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled         <= 1'b0;
            r_disable_pending <= 1'b0;
            r_hold_full       <= 1'b0;
            r_hold_word       <= '0;
            r_tx_shift        <= '0;
            r_rx_shift        <= '0;
            r_bit_count       <= '0;
            r_prescale        <= '0;
            r_clock_level     <= 1'b0;
            r_mosi_level      <= 1'b0;
        end else begin
            r_enabled         <= n_enabled;
            r_disable_pending <= n_disable_pending;
            r_hold_full       <= n_hold_full;
            r_hold_word       <= n_hold_word;
            r_tx_shift        <= n_tx_shift;
            r_rx_shift        <= n_rx_shift;
            r_bit_count       <= n_bit_count;
            r_prescale        <= n_prescale;
            r_clock_level     <= n_clock_level;
            r_mosi_level      <= n_mosi_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.sck       = r_out.sck;
    assign o_res.mosi      = r_out.mosi;
    assign o_res.nss       = r_out.nss;
    assign o_res.nss_drive = r_out.nss_drive;
    assign o_res.rx_word   = r_out.rx_word;
    assign o_res.rx_valid  = r_out.rx_valid;
    assign o_res.tx_ready  = r_out.tx_ready;
    assign o_res.busy_res  = r_out.busy_res;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rx_valid) |-> !r_out.busy_res)
        else $error("frame reported complete while still shifting");

    a_rx_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.rx_valid) |-> (r_out.rx_word == '0))
        else $error("received word shown without completion");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_bit_count) <= W)
        else $error("bit count beyond frame length");

    a_pending_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disable_pending |-> r_enabled)
        else $error("disable pending while not enabled");

    a_load_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_bit_count == '0) && (n_bit_count != '0)) |=> !r_hold_full
            || $past(i_item.action) == ACT_SEND)
        else $error("frame started without emptying the holding buffer");

endmodule

// ===== hw/rtl/spi_master_serializer.sv =====
// Top level of the SPI master serializer: configuration bank, input register, core.
// Depends on spim_pkg, spim_in_if, spim_out_if, spim_cfg, spim_in_stage, spim_core.
//
//   channel   dir  handshake            payload
//   i_req     in   valid/ready          action, tx_word, miso (one peripheral tick)
//   o_res     out  valid/ready          sck, mosi, nss, nss_drive, rx_word, rx_valid,
//                                       tx_ready, busy_res
//   cfg       in   i_cfg_we, no ready   i_cfg_index, i_cfg_data
//
// One request is taken every cycle unless o_res stalls; its result is offered on o_res
// after acceptance, through the input register, serializer logic, then result register.
// Reset is synchronous, active low, and clears all control and line state.
// A stalled result channel holds the result register and backs up to i_req.ready.
`timescale 1ns / 1ps

module spi_master_serializer #(
    parameter int MAX_FRAME_BITS = spim_pkg::DEF_MAX_FRAME_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    spim_in_if.sink                          i_req,
    spim_out_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [spim_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [spim_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import spim_pkg::*;

    t_spim_cfg  cfg;
    t_spim_item item;
    logic       item_valid;
    logic       core_ready;
    logic       take;

    assign take = item_valid && core_ready;

    spim_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    spim_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    spim_core #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (item_valid),
        .i_item  (item),
        .o_ready (core_ready),
        .o_res   (o_res)
    );

endmodule
